// ===== design/cbd_pkg.sv =====
// Shared types, constants and character decode helpers for the chunked body decoder.
package cbd_pkg;

  typedef enum logic [2:0] {
    PH_SIZE  = 3'd0,
    PH_SKIP  = 3'd1,
    PH_DATA  = 3'd2,
    PH_TRAIL = 3'd3,
    PH_DONE  = 3'd4,
    PH_HALT  = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_END     = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  // State of the hex number on the size line
  typedef enum logic [1:0] {
    DIG_OPEN   = 2'd0,  // leading blanks allowed
    DIG_IN     = 2'd1,  // digits seen
    DIG_CLOSED = 2'd2   // rest of line ignored
  } digits_e;

  localparam int unsigned CapW  = 21;
  localparam int unsigned SizeW = 31;

  localparam logic [7:0] ChCr  = 8'h0D;
  localparam logic [7:0] ChLf  = 8'h0A;
  localparam logic [7:0] ChSp  = 8'h20;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChVt  = 8'h0B;
  localparam logic [7:0] ChFf  = 8'h0C;

  localparam logic [CapW-1:0] CapReset = 21'd4096;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
  endfunction

  // Low nibble of the digit value; only meaningful when is_hex holds
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61) begin
      v = c - 8'h57;
    end else begin
      v = c - 8'h37;
    end
    hex_val = v[3:0];
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    is_blank = (c == ChSp) || (c == ChTab) || (c == ChVt) || (c == ChFf);
  endfunction

endpackage

// ===== design/chunked_body_decoder.sv =====
// Chunked transfer body decoder: parses size lines and passes chunk payload bytes out.
//
//  channel | dir | signals                                   | moves
//  --------+-----+-------------------------------------------+----------------------------
//  in      | in  | in_valid_i/in_ready_o, action_i, data_in_i| one byte or a start request
//  out     | out | out_valid_o/out_ready_i, kind_o,          | payload byte, end or error
//          |     | data_out_o, full_last_o, total_len_o      |
//  cfg     | in  | cfg_valid_i/cfg_ready_o, cfg_data_i       | capacity register write
//
// One byte per cycle unless the output stalls: each accepted byte updates the parse
// state, and any result lands in the output register the cycle after acceptance.
// A new byte is taken whenever the output register is empty or being drained.
// Reset (rst_ni low) clears the parse state and sets capacity to 4096.
// A stalled output holds its transaction and blocks input until taken.
module chunked_body_decoder
  import cbd_pkg::*;
#(
  parameter int unsigned SIZE_LINE_MAX = 50
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            action_i,
  input  logic [7:0]      data_in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      data_out_o,
  output logic            full_last_o,
  output logic [CapW-1:0] total_len_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [CapW-1:0] cfg_data_i
);

  localparam int unsigned LineW = $clog2(SIZE_LINE_MAX);
  localparam logic [LineW-1:0] LineLast = LineW'(SIZE_LINE_MAX - 1);

  phase_e          phase_q, phase_d;
  digits_e         digits_q, digits_d;
  logic [SizeW-1:0] size_q, size_d;
  logic [LineW-1:0] line_q, line_d;
  logic [CapW-1:0]  chunk_q, chunk_d;
  logic [1:0]       skip_q, skip_d;
  logic [CapW-1:0]  deliv_q, deliv_d;
  logic [CapW-1:0]  cap_q;

  logic            out_valid_q;
  kind_e           kind_q;
  logic [7:0]      data_out_q;
  logic            full_last_q;
  logic [CapW-1:0] total_len_q;

  logic            emit;
  kind_e           emit_kind;
  logic [7:0]      emit_data;
  logic            emit_full;
  logic [CapW-1:0] emit_total;

  logic            in_fire;
  logic [CapW-1:0] room;
  logic [CapW-1:0] deliv_inc;
  logic            full;
  logic [1:0]      skip_dec;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign room      = (cap_q > deliv_q) ? (cap_q - deliv_q) : CapW'(1);
  assign deliv_inc = deliv_q + CapW'(1);
  assign full      = deliv_inc >= cap_q;
  assign skip_dec  = (skip_q != 2'd0) ? (skip_q - 2'd1) : 2'd0;

  always_comb begin
    phase_d    = phase_q;
    digits_d   = digits_q;
    size_d     = size_q;
    line_d     = line_q;
    chunk_d    = chunk_q;
    skip_d     = skip_q;
    deliv_d    = deliv_q;
    emit       = 1'b0;
    emit_kind  = KIND_PAYLOAD;
    emit_data  = 8'd0;
    emit_full  = 1'b0;
    emit_total = deliv_q;

    if (in_fire) begin
      if (action_i) begin
        phase_d  = PH_SIZE;
        digits_d = DIG_OPEN;
        size_d   = '0;
        line_d   = '0;
        chunk_d  = '0;
        skip_d   = 2'd0;
        deliv_d  = '0;
      end else begin
        unique case (phase_q)
          PH_SIZE: begin
            if (data_in_i == ChCr || data_in_i == ChLf) begin
              if (size_q == '0) begin
                phase_d   = PH_DONE;
                emit      = 1'b1;
                emit_kind = KIND_END;
              end else begin
                phase_d = PH_SKIP;
                skip_d  = 2'd1;
              end
            end else if (line_q >= LineLast) begin
              phase_d   = PH_HALT;
              emit      = 1'b1;
              emit_kind = KIND_ERROR;
            end else begin
              line_d = line_q + LineW'(1);
              if (digits_q != DIG_CLOSED) begin
                if (is_hex(data_in_i)) begin
                  // next digit would push the size past 31 bits
                  if (size_q[SizeW-1:SizeW-4] != 4'd0) begin
                    phase_d   = PH_HALT;
                    emit      = 1'b1;
                    emit_kind = KIND_ERROR;
                  end else begin
                    size_d   = {size_q[SizeW-5:0], hex_val(data_in_i)};
                    digits_d = DIG_IN;
                  end
                end else if (is_blank(data_in_i)) begin
                  if (digits_q == DIG_IN) begin
                    digits_d = DIG_CLOSED;
                  end
                end else begin
                  digits_d = DIG_CLOSED;
                end
              end
            end
          end
          PH_SKIP: begin
            chunk_d = (size_q < {{(SizeW-CapW){1'b0}}, room}) ? size_q[CapW-1:0] : room;
            skip_d  = 2'd0;
            phase_d = PH_DATA;
          end
          PH_DATA: begin
            deliv_d    = deliv_inc;
            chunk_d    = (chunk_q != '0) ? (chunk_q - CapW'(1)) : chunk_q;
            emit       = 1'b1;
            emit_kind  = KIND_PAYLOAD;
            emit_data  = data_in_i;
            emit_full  = full;
            emit_total = deliv_inc;
            if (full) begin
              phase_d = PH_DONE;
              chunk_d = '0;
            end else if (chunk_q <= CapW'(1)) begin
              phase_d = PH_TRAIL;
              skip_d  = 2'd2;
            end
          end
          PH_TRAIL: begin
            skip_d = skip_dec;
            if (skip_dec == 2'd0) begin
              phase_d  = PH_SIZE;
              size_d   = '0;
              digits_d = DIG_OPEN;
              line_d   = '0;
            end
          end
          PH_DONE, PH_HALT: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SIZE;
      digits_q <= DIG_OPEN;
      size_q   <= '0;
      line_q   <= '0;
      chunk_q  <= '0;
      skip_q   <= 2'd0;
      deliv_q  <= '0;
      cap_q    <= CapReset;
    end else begin
      phase_q  <= phase_d;
      digits_q <= digits_d;
      size_q   <= size_d;
      line_q   <= line_d;
      chunk_q  <= chunk_d;
      skip_q   <= skip_d;
      deliv_q  <= deliv_d;
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && emit) begin
      kind_q      <= emit_kind;
      data_out_q  <= emit_data;
      full_last_q <= emit_full;
      total_len_q <= emit_total;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign data_out_o  = data_out_q;
  assign full_last_o = full_last_q;
  assign total_len_o = total_len_q;

  // Remaining chunk count is live only while passing data
  a_chunk_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) == (chunk_q != '0))
    else $error("chunk count out of step with phase");

  // A pending full_last transaction means the body has already ended
  a_full_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && full_last_q) |-> (phase_q == PH_DONE))
    else $error("full_last shown but body still open");

  // Non-payload transactions carry no byte and no full flag
  a_nonpayload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q != KIND_PAYLOAD) |-> (data_out_q == 8'd0 && !full_last_q))
    else $error("end or error transaction carries payload");

  // Start request clears the body state
  a_start_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && action_i) |=> (phase_q == PH_SIZE && deliv_q == '0 && size_q == '0))
    else $error("start request did not clear state");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the chunked body decoder: directed table, then random bodies.
`timescale 1ns / 1ps

module testbench
  import cbd_pkg::*;
();

  localparam int          LineMax    = 50;
  localparam int          DirRows    = 27;
  localparam int          PhaseItems = 190;
  localparam int unsigned CycleLimit = 400_000;

  typedef struct packed {
    kind_e           kind;
    logic [7:0]      data;
    logic            full;
    logic [CapW-1:0] total;
  } body_result_t;

  // How a directed row is checked: by the predictor, by a typed result, or as silent
  typedef enum logic [1:0] {
    ROW_MODEL  = 2'd0,
    ROW_RESULT = 2'd1,
    ROW_QUIET  = 2'd2
  } row_mode_e;

  typedef struct packed {
    logic         act;
    logic [7:0]   ch;
    row_mode_e    mode;
    body_result_t res;
  } drive_row_t;

  localparam body_result_t NoRes = '0;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            in_valid_i  = 1'b0;
  logic            in_ready_o;
  logic            action_i    = 1'b0;
  logic [7:0]      data_in_i   = 8'h00;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  logic [1:0]      kind_o;
  logic [7:0]      data_out_o;
  logic            full_last_o;
  logic [CapW-1:0] total_len_o;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [CapW-1:0] cfg_data_i  = '0;

  // Predictor state
  phase_e          phase_q;
  logic [31:0]     size_acc;
  digits_e         dig_q;
  int              line_cnt;
  logic [31:0]     chunk_left;
  logic [1:0]      skip_left;
  logic [CapW-1:0] delivered;
  logic [CapW-1:0] capacity_q;

  body_result_t pending_results [$];
  drive_row_t   dir_rows [DirRows];
  int           errors     = 0;
  int           live_items = 0;
  bit           calm       = 1'b0;
  bit           hold_req   = 1'b0;

  chunked_body_decoder #(
    .SIZE_LINE_MAX(LineMax)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .data_in_i  (data_in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .kind_o     (kind_o),
    .data_out_o (data_out_o),
    .full_last_o(full_last_o),
    .total_len_o(total_len_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void clear_body();
    phase_q    = PH_SIZE;
    size_acc   = '0;
    dig_q      = DIG_OPEN;
    line_cnt   = 0;
    chunk_left = '0;
    skip_left  = '0;
    delivered  = '0;
  endfunction

  // Advances the predictor by one accepted byte; returns 1 when a result is due
  function automatic bit decode_byte(input logic act, input logic [7:0] c,
                                     output body_result_t r);
    logic [31:0] room;
    int          nib;
    bit          got;
    r   = NoRes;
    got = 1'b0;
    if (act) begin
      clear_body();
      return 1'b0;
    end
    case (phase_q)
      PH_SIZE: begin
        if (c == ChCr || c == ChLf) begin
          if (size_acc == 0) begin
            phase_q = PH_DONE;
            r.kind  = KIND_END;
            got     = 1'b1;
          end else begin
            phase_q   = PH_SKIP;
            skip_left = 2'd1;
          end
        end else begin
          line_cnt++;
          if (line_cnt >= LineMax) begin
            phase_q = PH_HALT;
            r.kind  = KIND_ERROR;
            got     = 1'b1;
          end else if (dig_q != DIG_CLOSED) begin
            if (c >= 8'h30 && c <= 8'h39) nib = int'(c) - 48;
            else if (c >= 8'h61 && c <= 8'h66) nib = int'(c) - 87;
            else if (c >= 8'h41 && c <= 8'h46) nib = int'(c) - 55;
            else nib = -1;
            if (nib >= 0) begin
              if (size_acc > 32'h07FF_FFFF) begin
                phase_q = PH_HALT;
                r.kind  = KIND_ERROR;
                got     = 1'b1;
              end else begin
                size_acc = {size_acc[27:0], nib[3:0]};
                dig_q    = DIG_IN;
              end
            end else if (c == ChSp || c == ChTab || c == ChVt || c == ChFf) begin
              if (dig_q == DIG_IN) dig_q = DIG_CLOSED;
            end else begin
              dig_q = DIG_CLOSED;
            end
          end
        end
      end
      PH_SKIP: begin
        room       = (capacity_q > delivered) ? 32'(capacity_q - delivered) : 32'd1;
        chunk_left = (size_acc < room) ? size_acc : room;
        skip_left  = '0;
        phase_q    = PH_DATA;
      end
      PH_DATA: begin
        delivered = delivered + 1'b1;
        if (chunk_left > 0) chunk_left--;
        r.full = (delivered >= capacity_q);
        if (r.full) begin
          phase_q    = PH_DONE;
          chunk_left = '0;
        end else if (chunk_left == 0) begin
          phase_q   = PH_TRAIL;
          skip_left = 2'd2;
        end
        r.kind = KIND_PAYLOAD;
        r.data = c;
        got    = 1'b1;
      end
      PH_TRAIL: begin
        if (skip_left > 0) skip_left--;
        if (skip_left == 0) begin
          phase_q  = PH_SIZE;
          size_acc = '0;
          dig_q    = DIG_OPEN;
          line_cnt = 0;
        end
      end
      default: ;
    endcase
    r.total = delivered;
    return got;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + v;
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 8'd10;
  endfunction

  function automatic logic [7:0] any_but_eol();
    logic [7:0] c;
    c = 8'($urandom);
    while (c == ChCr || c == ChLf) c = 8'($urandom);
    return c;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 3))
      0:       return ChSp;
      1:       return ChTab;
      2:       return ChVt;
      default: return ChFf;
    endcase
  endfunction

  task automatic flag_mismatch(input string field, input int unsigned want_v,
                               input int unsigned got_v);
    errors++;
    $error("%s: expected %0d, got %0d", field, want_v, got_v);
  endtask

  task automatic push_byte(input logic act, input logic [7:0] ch, input row_mode_e mode,
                           input body_result_t typed);
    body_result_t r;
    bit           got;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    data_in_i  <= ch;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    live_items++;
    got = decode_byte(act, ch, r);
    if (mode == ROW_RESULT) pending_results.push_back(typed);
    else if (mode == ROW_MODEL && got) pending_results.push_back(r);
  endtask

  task automatic feed(input logic [7:0] ch);
    push_byte(1'b0, ch, ROW_MODEL, NoRes);
  endtask

  task automatic restart_body();
    push_byte(1'b1, 8'($urandom), ROW_MODEL, NoRes);
  endtask

  task automatic send_size_line(input logic [35:0] val, input int ndig, input bit crlf);
    int i;
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) feed(blank_char());
    for (i = ndig - 1; i >= 0; i--) feed(hex_char(val[4*i +: 4]));
    // optional extension, always opened by a non-hex character
    case ($urandom_range(0, 5))
      0: begin
        feed(blank_char());
        feed(8'h3B);
        repeat ($urandom_range(0, 4)) feed(any_but_eol());
      end
      1: begin
        feed($urandom_range(0, 1) ? 8'h2D : 8'h78);
        repeat ($urandom_range(0, 4)) feed(any_but_eol());
      end
      default: ;
    endcase
    feed(crlf ? ChCr : ChLf);
  endtask

  task automatic send_chunk(input int size);
    bit crlf;
    int nd;
    crlf = $urandom_range(0, 4) != 0;
    nd   = 1;
    while ((size >> (4 * nd)) != 0) nd++;
    if ($urandom_range(0, 3) == 0) nd += $urandom_range(1, 2);
    send_size_line(36'(size), nd, crlf);
    // bare LF: the next byte is skipped whatever it is
    feed(crlf ? ChLf : 8'($urandom));
    repeat (size) feed(8'($urandom));
    if ($urandom_range(0, 7) == 0) begin
      feed(8'($urandom));
      feed(8'($urandom));
    end else begin
      feed(ChCr);
      feed(ChLf);
    end
  endtask

  task automatic send_unit();
    int n;
    int k;
    case ($urandom_range(0, 11))
      0: begin
        // size line around the length limit
        restart_body();
        n = $urandom_range(47, 52);
        k = $urandom_range(0, 3);
        repeat (k) feed(blank_char());
        feed(8'h33);
        feed(8'h3B);
        repeat (n - k - 2) feed(any_but_eol());
        feed(ChCr);
        feed(ChLf);
        repeat (3) feed(8'($urandom));
        feed(ChCr);
        feed(ChLf);
      end
      1: begin
        restart_body();
        if ($urandom_range(0, 2) == 0) begin
          send_size_line(36'h0_7FFF_FFFF, 8, 1'b1);
          feed(ChLf);
          repeat ($urandom_range(1, 4)) feed(8'($urandom));
        end else begin
          send_size_line({4'($urandom_range(1, 15)), 32'($urandom)}, 9, 1'b1);
        end
      end
      2: begin
        repeat ($urandom_range(4, 16)) begin
          if ($urandom_range(0, 7) == 0) restart_body();
          else feed(8'($urandom));
        end
      end
      3: send_chunk($urandom_range(1, 12));
      default: begin
        restart_body();
        repeat ($urandom_range(0, 4)) begin
          if ($urandom_range(0, 9) == 0) send_chunk($urandom_range(13, 300));
          else send_chunk($urandom_range(1, 12));
        end
        send_size_line('0, $urandom_range(0, 3), 1'b1);
        feed(ChLf);
      end
    endcase
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    // a byte without a result may still be in the pipe
    repeat (4) @(posedge clk_i);
  endtask

  initial begin : drain_side
    body_result_t want;
    int           stall_left;
    bit           hold_seen;
    stall_left = 0;
    hold_seen  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          errors++;
          $error("transaction with no result pending: kind %0d", kind_o);
        end else begin
          want = pending_results.pop_front();
          if (kind_o != want.kind) flag_mismatch("kind", want.kind, kind_o);
          if (data_out_o != want.data) flag_mismatch("data_out", want.data, data_out_o);
          if (full_last_o != want.full) flag_mismatch("full_last", want.full, full_last_o);
          if (total_len_o != want.total) flag_mismatch("total_len", want.total, total_len_o);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (hold_req && !hold_seen) begin
        hold_seen   = 1'b1;
        stall_left  = 299;
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left  = $urandom_range(0, 6);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("testbench failed");
    $finish;
  end

  initial begin : stimulus
    logic [CapW-1:0] cap_next;
    int              p;
    capacity_q = CapReset;
    clear_body();
    dir_rows = '{
      '{1'b1, 8'hA5, ROW_QUIET,  NoRes},
      '{1'b0, ChLf,  ROW_RESULT, '{KIND_END, 8'h00, 1'b0, 21'd0}},  // empty size line
      '{1'b0, 8'hFF, ROW_QUIET,  NoRes},                           // ignored after end
      '{1'b1, 8'h00, ROW_QUIET,  NoRes},
      '{1'b0, ChTab, ROW_MODEL,  NoRes},                           // leading blank
      '{1'b0, 8'h32, ROW_MODEL,  NoRes},
      '{1'b0, 8'h3B, ROW_MODEL,  NoRes},                           // closes the number
      '{1'b0, 8'h46, ROW_MODEL,  NoRes},
      '{1'b0, ChCr,  ROW_MODEL,  NoRes},
      '{1'b0, ChLf,  ROW_MODEL,  NoRes},
      '{1'b0, 8'h00, ROW_RESULT, '{KIND_PAYLOAD, 8'h00, 1'b0, 21'd1}},
      '{1'b0, 8'hFF, ROW_RESULT, '{KIND_PAYLOAD, 8'hFF, 1'b0, 21'd2}},
      '{1'b0, ChCr,  ROW_MODEL,  NoRes},
      '{1'b0, ChLf,  ROW_MODEL,  NoRes},
      '{1'b0, 8'h46, ROW_MODEL,  NoRes},
      '{1'b0, 8'h66, ROW_MODEL,  NoRes},
      '{1'b0, 8'h46, ROW_MODEL,  NoRes},
      '{1'b0, 8'h66, ROW_MODEL,  NoRes},
      '{1'b0, 8'h46, ROW_MODEL,  NoRes},
      '{1'b0, 8'h66, ROW_MODEL,  NoRes},
      '{1'b0, 8'h46, ROW_MODEL,  NoRes},
      '{1'b0, 8'h66, ROW_RESULT, '{KIND_ERROR, 8'h00, 1'b0, 21'd2}},  // size overflow
      '{1'b1, 8'hFF, ROW_QUIET,  NoRes},
      '{1'b0, 8'h31, ROW_MODEL,  NoRes},
      '{1'b0, ChLf,  ROW_MODEL,  NoRes},                           // bare LF
      '{1'b0, 8'h5A, ROW_MODEL,  NoRes},                           // skipped although data
      '{1'b0, 8'hC3, ROW_MODEL,  NoRes}
    };
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) push_byte(dir_rows[i].act, dir_rows[i].ch, dir_rows[i].mode,
                                    dir_rows[i].res);
    for (p = 0; p < 10; p++) begin
      wait_drained();
      case (p)
        0:       cap_next = 21'd1;
        1:       cap_next = 21'd1048576;
        2:       cap_next = '0;
        3:       cap_next = 21'($urandom_range(2, 24));
        4:       cap_next = CapReset;
        5:       cap_next = 21'($urandom_range(1, 1048576));
        6:       cap_next = 21'd3;
        7:       cap_next = 21'($urandom_range(8, 64));
        8:       cap_next = 21'd1048576;
        default: cap_next = 21'($urandom_range(2, 24));
      endcase
      cfg_valid_i <= 1'b1;
      cfg_data_i  <= cap_next;
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      cfg_valid_i <= 1'b0;
      capacity_q = cap_next;
      calm       = (p == 9);
      if (p == 1) begin
        // long output stall while a 60-byte chunk keeps coming
        restart_body();
        hold_req = 1'b1;
        send_chunk(60);
      end
      while (live_items < (p + 1) * PhaseItems) send_unit();
    end
    wait_drained();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
